[hw/rtl/double_ended_queue_with_reverse_top_defines.svh]
// Assertion helpers for the deque block; each expects clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_WITH_REVERSE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_REVERSE_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DQR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DQR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dqr_pkg.sv]
package dqr_pkg;

  // Ring depth and derived widths
  localparam int DEPTH = 256;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_REVERSE    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [DATA_W-1:0]  push_value;
  } in_word_t;

  typedef struct packed {
    logic                      ok;
    logic signed [DATA_W-1:0]  popped_value;
    logic [CNT_W-1:0]          element_count;
  } out_word_t;

  // Single-port ring store access
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  // Registered result, less the read data from the store
  typedef struct packed {
    logic              valid;
    logic              ok;
    logic              pop_sel;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage

[hw/rtl/dqr_ram.sv]
module dqr_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/dqr_ctrl.sv]
`include "double_ended_queue_with_reverse_top_defines.svh"

module dqr_ctrl
  import dqr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  in_word_t in_word,
  output mem_req_t mem_req,
  output res_t     res
);

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rev_r, rev_nxt;
  res_t             res_r, res_nxt;

  logic             full, empty, ok_c, pop_sel_c, at_start;
  logic [IDX_W-1:0] prev_front, next_front, end_slot, last_slot;
  logic [SUM_W-1:0] end_sum, last_sum;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  // Neighbouring slots of the physical first element
  assign prev_front = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign next_front = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;

  // Slot after the physical end, and the physical last slot; both sums stay below 2*DEPTH
  assign end_sum  = SUM_W'(front_r) + SUM_W'(cnt_r);
  assign last_sum = end_sum - 1'b1;

  always_comb begin
    logic [SUM_W-1:0] e, l;
    e = (end_sum >= SUM_W'(DEPTH)) ? end_sum - SUM_W'(DEPTH) : end_sum;
    l = (last_sum >= SUM_W'(DEPTH)) ? last_sum - SUM_W'(DEPTH) : last_sum;
    end_slot  = e[IDX_W-1:0];
    last_slot = l[IDX_W-1:0];
  end

  assign at_start = (in_word.mode == MODE_PUSH_FRONT) == !rev_r;

  // Decode the request and form the store access
  always_comb begin
    front_nxt = front_r;
    cnt_nxt   = cnt_r;
    rev_nxt   = rev_r;
    ok_c      = 1'b0;
    pop_sel_c = 1'b0;
    mem_req   = '0;
    mem_req.wdata = in_word.push_value;
    if (acc) begin
      unique case (in_word.mode) inside
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (!full) begin
            ok_c          = 1'b1;
            cnt_nxt       = cnt_r + 1'b1;
            mem_req.wr_en = 1'b1;
            if (at_start) begin
              front_nxt    = prev_front;
              mem_req.addr = prev_front;
            end else begin
              mem_req.addr = end_slot;
            end
          end
        end
        MODE_POP_FRONT: begin
          if (!empty) begin
            ok_c          = 1'b1;
            pop_sel_c     = 1'b1;
            cnt_nxt       = cnt_r - 1'b1;
            mem_req.rd_en = 1'b1;
            if (!rev_r) begin
              mem_req.addr = front_r;
              front_nxt    = next_front;
            end else begin
              mem_req.addr = last_slot;
            end
          end
        end
        MODE_REVERSE: begin
          rev_nxt = ~rev_r;
          ok_c    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_nxt         = '0;
    res_nxt.valid   = acc;
    res_nxt.ok      = ok_c;
    res_nxt.pop_sel = pop_sel_c;
    res_nxt.count   = cnt_nxt;
  end

  // Advance pointers and register the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
      rev_r   <= 1'b0;
      res_r   <= '0;
    end else begin
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
      rev_r   <= rev_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res = res_r;

  `DQR_ASSERT_NOW(a_count_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "count above depth")
  `DQR_ASSERT_NEXT(a_push_count, acc && mem_req.wr_en, cnt_r == $past(cnt_r) + 1'b1,
                   "push did not add one word")
  `DQR_ASSERT_NEXT(a_fail_hold, acc && !ok_c, $stable(front_r) && $stable(cnt_r),
                   "failed request changed the queue")
  `DQR_ASSERT_NEXT(a_result_follows, acc, res_r.valid && (res_r.count == cnt_r),
                   "result missing or count mismatch")

endmodule

[hw/rtl/double_ended_queue_with_reverse_top.sv]
// Bounded deque of signed 32-bit words in a single-port ring store of DEPTH entries.
// A request is taken on every cycle with start high and busy low, one per cycle; busy is
// high only for the first cycle after reset, and no clearing pass is run. Each request
// does at most one store access (a write for a push, a read for a pop), so its result is
// strobed on out_strobe for one cycle, the cycle after the request was taken, with the
// popped word straight from the store's read register. Results cannot be held off: the
// receiver must take each word in the cycle it is shown. Reverse moves no entries.
module double_ended_queue_with_reverse_top
  import dqr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  logic              busy_r;
  logic              acc;
  mem_req_t          mem_req;
  res_t              res;
  logic [DATA_W-1:0] rdata;

  // Hold busy for one cycle out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign acc  = start && !busy_r;

  dqr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_word (in_word),
    .mem_req (mem_req),
    .res     (res)
  );

  dqr_ram #(
    .DATA_W (DATA_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .wr_en (mem_req.wr_en),
    .rd_en (mem_req.rd_en),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  // Assemble the result word; drop read data unless this was a pop
  assign out_strobe             = res.valid;
  assign out_word.ok            = res.ok;
  assign out_word.popped_value  = res.pop_sel ? signed'(rdata) : '0;
  assign out_word.element_count = res.count;

endmodule

[tb/sv/testbench.sv]
module testbench;
  import dqr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1750;
  localparam int MAX_GAP      = 30;
  localparam int SETTLE_LIMIT = 50;

  // Bias of a random segment: grow the queue, shrink it, or keep it level
  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_LEVEL} bias_t;

  // Track the deque contents and queue up the result each request should give
  class deque_scoreboard;
    logic signed [DATA_W-1:0] ring [DEPTH];
    int unsigned              head;
    int unsigned              fill;
    logic                     flipped;
    out_word_t                awaited [$];
    int                       errors;

    function new();
      head    = 0;
      fill    = 0;
      flipped = 1'b0;
      errors  = 0;
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    function int pending();
      return awaited.size();
    endfunction

    // Apply one accepted request and note the result it must produce
    function void note_request(input in_word_t w);
      out_word_t res;
      logic      at_start;
      res = '0;
      case (w.mode)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (fill < DEPTH) begin
            at_start = (w.mode == MODE_PUSH_FRONT) == !flipped;
            if (at_start) begin
              head = (head == 0) ? DEPTH - 1 : head - 1;
              ring[head] = w.push_value;
            end else begin
              ring[(head + fill) % DEPTH] = w.push_value;
            end
            fill++;
            res.ok = 1'b1;
          end
        end
        MODE_POP_FRONT: begin
          if (fill > 0) begin
            if (!flipped) begin
              res.popped_value = ring[head];
              head = (head + 1) % DEPTH;
            end else begin
              res.popped_value = ring[(head + fill - 1) % DEPTH];
            end
            fill--;
            res.ok = 1'b1;
          end
        end
        default: begin
          flipped = !flipped;
          res.ok  = 1'b1;
        end
      endcase
      res.element_count = fill[CNT_W-1:0];
      awaited.push_back(res);
    endfunction

    // Compare one strobed result with the oldest expectation
    task check_result(input out_word_t got);
      out_word_t exp_word;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        exp_word = awaited.pop_front();
        if (got.ok !== exp_word.ok)
          report_mismatch($sformatf("ok %b, wanted %b", got.ok, exp_word.ok));
        if (got.popped_value !== exp_word.popped_value)
          report_mismatch($sformatf("popped_value %h, wanted %h",
                                    got.popped_value, exp_word.popped_value));
        if (got.element_count !== exp_word.element_count)
          report_mismatch($sformatf("element_count %0d, wanted %0d",
                                    got.element_count, exp_word.element_count));
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;

  deque_scoreboard sb = new();
  int              words_sent;

  double_ended_queue_with_reverse_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  always #4 clk = ~clk;

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_word);
      if (start && !busy) sb.note_request(in_word);
    end
  end

  function automatic in_word_t make_word(input mode_t m, input logic [DATA_W-1:0] v);
    in_word_t w;
    w.mode       = m;
    w.push_value = v;
    return w;
  endfunction

  // Present one word after a random idle gap and hold it until taken
  task automatic send_word(input in_word_t w, input int idle_pct);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // Hold off the sender until every awaited result is in, or the wait limit runs out
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() > 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_word_t pick_word(input bias_t bias);
    int    r;
    mode_t m;
    r = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  m = (r < 85) ? mode_t'($urandom_range(0, 1)) :
                      (r < 93) ? MODE_POP_FRONT : MODE_REVERSE;
      BIAS_DRAIN: m = (r < 85) ? MODE_POP_FRONT :
                      (r < 93) ? mode_t'($urandom_range(0, 1)) : MODE_REVERSE;
      default:    m = (r < 30) ? MODE_PUSH_FRONT :
                      (r < 60) ? MODE_PUSH_BACK :
                      (r < 90) ? MODE_POP_FRONT : MODE_REVERSE;
    endcase
    return make_word(m, pick_value());
  endfunction

  // Directed opening: empty and single-entry corners, extreme values, all modes
  task automatic run_directed();
    in_word_t seq [$];
    seq.push_back(make_word(MODE_POP_FRONT,  32'h0));
    seq.push_back(make_word(MODE_REVERSE,    32'hffff_ffff));
    seq.push_back(make_word(MODE_POP_FRONT,  32'hffff_ffff));
    seq.push_back(make_word(MODE_REVERSE,    32'h0));
    seq.push_back(make_word(MODE_PUSH_BACK,  32'h7fff_ffff));
    seq.push_back(make_word(MODE_POP_FRONT,  32'h1234_5678));
    seq.push_back(make_word(MODE_PUSH_FRONT, 32'h8000_0000));
    seq.push_back(make_word(MODE_REVERSE,    32'h0));
    seq.push_back(make_word(MODE_POP_FRONT,  32'h0));
    seq.push_back(make_word(MODE_PUSH_FRONT, 32'hffff_ffff));
    seq.push_back(make_word(MODE_PUSH_BACK,  32'h0000_0000));
    seq.push_back(make_word(MODE_PUSH_FRONT, 32'h5555_5555));
    seq.push_back(make_word(MODE_PUSH_BACK,  32'haaaa_aaaa));
    seq.push_back(make_word(MODE_REVERSE,    32'h0));
    seq.push_back(make_word(MODE_POP_FRONT,  32'h0));
    seq.push_back(make_word(MODE_PUSH_FRONT, 32'h0000_0001));
    seq.push_back(make_word(MODE_PUSH_BACK,  32'h7fff_ffff));
    seq.push_back(make_word(MODE_POP_FRONT,  32'h0));
    seq.push_back(make_word(MODE_REVERSE,    32'h0));
    for (int i = 0; i < 6; i++) seq.push_back(make_word(MODE_POP_FRONT, 32'h0));
    foreach (seq[i]) send_word(seq[i], 26);
  endtask

  initial begin
    int    phase_pct [3];
    int    seg_len;
    int    seg_pct;
    int    seg_idx;
    bias_t bias;

    phase_pct  = '{26, 69, 0};
    rst_n      = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    words_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    // Random segments alternate fill, drain and level so full and empty recur
    seg_idx = 0;
    for (int phase = 0; phase < 3; phase++) begin
      while (words_sent < (phase + 1) * RANDOM_WORDS / 3) begin
        bias    = bias_t'(seg_idx % 3);
        seg_len = (bias == BIAS_LEVEL) ? $urandom_range(100, 200) : $urandom_range(300, 420);
        seg_pct = ($urandom_range(0, 3) == 0) ? 0 : phase_pct[phase];
        for (int i = 0; i < seg_len && words_sent < (phase + 1) * RANDOM_WORDS / 3; i++)
          send_word(pick_word(bias), seg_pct);
        seg_idx++;
      end
      settle();
    end

    if (sb.pending() > 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("PASS double_ended_queue_with_reverse_top");
    end else begin
      $display("FAIL double_ended_queue_with_reverse_top");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5ms;
    $display("FAIL double_ended_queue_with_reverse_top");
    $finish;
  end

endmodule
